### hdl/ffha_pkg.sv
// Shared types, codes and defaults for the first-fit heap allocator.
// Used by ffha_alu and first_fit_heap_allocator_core; depends on nothing.
package ffha_pkg;

   // Default configuration of the block table and arena.
   localparam int MaxBlocksDef   = 64;
   localparam int ArenaBytesDef  = 65536;
   localparam int HeaderBytesDef = 40;

   // Payload addresses stay within a 16-bit address space.
   localparam int AddrSpace = 65536;
   localparam int LimitW    = 17;
   localparam int SizeW     = 16;
   localparam int AluW      = 18;

   // Reset value of the heap limit register.
   localparam logic [LimitW-1:0] LimitReset = 17'd65536;

   // Request modes.
   localparam logic ModeAlloc = 1'b0;
   localparam logic ModeFree  = 1'b1;

   // Result status codes.
   localparam logic StatusOk   = 1'b0;
   localparam logic StatusFail = 1'b1;

   // Operations of the shared arithmetic unit.
   typedef enum logic {
      ALU_ADD_HDR,
      ALU_SUB
   } alu_op_type;

   // Result of the shared arithmetic unit.
   typedef struct packed {
      logic [AluW-1:0] value;
      logic            borrow;
   } alu_res_type;

   // One request beat.
   typedef struct packed {
      logic             mode;
      logic [SizeW-1:0] request_size;
      logic [15:0]      address;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [15:0] result_address;
      logic        status;
   } rsp_type;

   // One entry of the block table.
   typedef struct packed {
      logic             free;
      logic [SizeW-1:0] size;
   } ent_type;

endpackage

### hdl/ffha_alu.sv
// Shared adder and subtractor of the allocator sequencer.
// Depends on ffha_pkg for operation codes and result type.
module ffha_alu #(
   parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDef
) (
   input  ffha_pkg::alu_op_type           op,
   input  logic [ffha_pkg::AluW-1:0]      op_a,
   input  logic [ffha_pkg::AluW-1:0]      op_b,
   output ffha_pkg::alu_res_type          res
);

   localparam logic [ffha_pkg::AluW:0] Hdr = (ffha_pkg::AluW+1)'(HEADER_BYTES);

   logic [ffha_pkg::AluW:0] sum;

   // Either a + b + header, or a - b with the borrow out of the top.
   always_comb begin
      case (op)
         ffha_pkg::ALU_ADD_HDR: sum = {1'b0, op_a} + {1'b0, op_b} + Hdr;
         ffha_pkg::ALU_SUB:     sum = {1'b0, op_a} - {1'b0, op_b};
         default:               sum = '0;
      endcase
      res.value  = sum[ffha_pkg::AluW-1:0];
      res.borrow = (op == ffha_pkg::ALU_SUB) ? sum[ffha_pkg::AluW] : 1'b0;
   end

endmodule

### hdl/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: sequencer, block table memory.
// Depends on ffha_pkg and the shared arithmetic unit ffha_alu.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+---------------------------------
//   request | req_valid, req_stall, req_data | mode, request_size, address
//   result  | rsp_valid, rsp_stall, rsp_data | result_address, status
//   config  | csr_valid, csr_ready, csr_data | heap_limit, 17 bits
//
// One request is worked at a time; req_stall is high until its result is
// registered. An allocate walk reads and checks each block it passes, a free
// walk does the same, and a table shift reads and writes each moved entry
// in turn, as the single shared adder and the one-port table read demand.
// Reset is synchronous and clears the control state; the table needs none.
// A held result in the output register waits for rsp_stall to drop.
module first_fit_heap_allocator_core #(
   parameter int MAX_BLOCKS   = ffha_pkg::MaxBlocksDef,
   parameter int ARENA_BYTES  = ffha_pkg::ArenaBytesDef,
   parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDef
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ffha_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ffha_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ffha_pkg::LimitW-1:0]      csr_data
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int LW = ffha_pkg::LimitW;
   localparam int SW = ffha_pkg::SizeW;
   localparam int AW = ffha_pkg::AluW;
   localparam logic [LW-1:0] LimitCap = (ARENA_BYTES < ffha_pkg::AddrSpace) ?
      LW'(ARENA_BYTES) : LW'(ffha_pkg::AddrSpace);
   localparam logic [AW-1:0] HdrA   = AW'(HEADER_BYTES);
   localparam logic [AW-1:0] SplitA = AW'(HEADER_BYTES + 8);
   localparam logic [CW-1:0] MaxC   = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] OneC   = CW'(1);

   typedef enum logic [4:0] {
      S_IDLE, S_A_RD, S_A_EV, S_A_STEP, S_A_FIT, S_A_ADDR, S_A_REM,
      S_A_GROW, S_A_LIM, S_A_APP, S_IN_RD, S_IN_WR,
      S_F_PRE, S_F_RD, S_F_EV, S_F_STEP, S_F_MRGP, S_F_NXT, S_F_NEV,
      S_F_MRGN, S_RM_RD, S_RM_WR, S_RESP
   } state_type;

   // Sequencer registers.
   state_type          state_ff, state_in;
   logic [LW-1:0]      s_ff, s_in;
   logic [LW-1:0]      tgt_ff, tgt_in;
   logic               tgt_ok_ff, tgt_ok_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      ins_pos_ff, ins_pos_in;
   logic [LW-1:0]      off_ff, off_in;
   logic [LW-1:0]      prev_off_ff, prev_off_in;
   logic [SW-1:0]      prev_size_ff, prev_size_in;
   logic               prev_free_ff, prev_free_in;
   logic [CW-1:0]      cur_ff, cur_in;
   logic [SW-1:0]      cur_size_ff, cur_size_in;
   logic [LW-1:0]      cur_off_ff, cur_off_in;
   logic [SW-1:0]      rem_ff, rem_in;
   logic               split_ff, split_in;
   logic [LW-1:0]      grow_ff, grow_in;
   ffha_pkg::ent_type  new_ent_ff, new_ent_in;
   logic [15:0]        res_addr_ff, res_addr_in;
   logic               status_ff, status_in;
   logic               rm_ret_ff, rm_ret_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [LW-1:0]      top_ff, top_in;
   logic [LW-1:0]      limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // Block table memory and its ports.
   ffha_pkg::ent_type  table_mem [MAX_BLOCKS];
   ffha_pkg::ent_type  rd_data_ff;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   ffha_pkg::ent_type  wr_data;

   // Shared arithmetic unit.
   ffha_pkg::alu_op_type  alu_op;
   logic [AW-1:0]         alu_a;
   logic [AW-1:0]         alu_b;
   ffha_pkg::alu_res_type alu_res;

   ffha_alu #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_alu (
      .op   (alu_op),
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      tgt_in       = tgt_ff;
      tgt_ok_in    = tgt_ok_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      ins_pos_in   = ins_pos_ff;
      off_in       = off_ff;
      prev_off_in  = prev_off_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      cur_in       = cur_ff;
      cur_size_in  = cur_size_ff;
      cur_off_in   = cur_off_ff;
      rem_in       = rem_ff;
      split_in     = split_ff;
      grow_in      = grow_ff;
      new_ent_in   = new_ent_ff;
      res_addr_in  = res_addr_ff;
      status_in    = status_ff;
      rm_ret_in    = rm_ret_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = rd_data_ff;
      alu_op       = ffha_pkg::ALU_SUB;
      alu_a        = '0;
      alu_b        = '0;

      // Configuration beat: keep the limit already clamped to the arena.
      if (csr_valid) begin
         limit_in = (csr_data > LimitCap) ? LimitCap : csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            idx_in       = '0;
            off_in       = '0;
            prev_free_in = 1'b0;
            res_addr_in  = '0;
            status_in    = ffha_pkg::StatusOk;
            if (req_valid) begin
               if (req_data.mode == ffha_pkg::ModeFree) begin
                  // Capture the address; the request port may move on.
                  tgt_in   = LW'(req_data.address);
                  state_in = S_F_PRE;
               end else if (req_data.request_size == '0) begin
                  status_in = ffha_pkg::StatusFail;
                  state_in  = S_RESP;
               end else begin
                  s_in     = ({1'b0, req_data.request_size} + LW'(7)) & ~LW'(7);
                  state_in = S_A_RD;
               end
            end
         end

         // Allocate: first-fit walk over the table.
         S_A_RD: begin
            if (idx_ff == cnt_ff) begin
               if (cnt_ff >= MaxC) begin
                  status_in = ffha_pkg::StatusFail;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_A_GROW;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_A_EV;
            end
         end
         S_A_EV: begin
            alu_op = ffha_pkg::ALU_SUB;
            alu_a  = AW'(rd_data_ff.size);
            alu_b  = AW'(s_ff);
            if (rd_data_ff.free && !alu_res.borrow) begin
               rem_in   = alu_res.value[SW-1:0];
               state_in = S_A_FIT;
            end else begin
               state_in = S_A_STEP;
            end
         end
         S_A_STEP: begin
            alu_op   = ffha_pkg::ALU_ADD_HDR;
            alu_a    = AW'(off_ff);
            alu_b    = AW'(rd_data_ff.size);
            off_in   = alu_res.value[LW-1:0];
            idx_in   = idx_ff + OneC;
            state_in = S_A_RD;
         end
         S_A_FIT: begin
            alu_op   = ffha_pkg::ALU_SUB;
            alu_a    = AW'(rem_ff);
            alu_b    = SplitA;
            split_in = !alu_res.borrow && (cnt_ff < MaxC);
            wr_en    = 1'b1;
            wr_data.free = 1'b0;
            wr_data.size = (!alu_res.borrow && (cnt_ff < MaxC)) ?
               s_ff[SW-1:0] : rd_data_ff.size;
            state_in = S_A_ADDR;
         end
         S_A_ADDR: begin
            alu_op      = ffha_pkg::ALU_ADD_HDR;
            alu_a       = AW'(off_ff);
            alu_b       = '0;
            res_addr_in = alu_res.value[15:0];
            state_in    = split_ff ? S_A_REM : S_RESP;
         end
         S_A_REM: begin
            alu_op          = ffha_pkg::ALU_SUB;
            alu_a           = AW'(rem_ff);
            alu_b           = HdrA;
            new_ent_in.free = 1'b1;
            new_ent_in.size = alu_res.value[SW-1:0];
            ins_pos_in      = idx_ff + OneC;
            k_in            = cnt_ff;
            state_in        = S_IN_RD;
         end

         // Allocate: append a block at the heap top.
         S_A_GROW: begin
            alu_op   = ffha_pkg::ALU_ADD_HDR;
            alu_a    = AW'(top_ff);
            alu_b    = AW'(s_ff);
            grow_in  = alu_res.value[LW-1:0];
            state_in = alu_res.value[AW-1] ? S_RESP : S_A_LIM;
            if (alu_res.value[AW-1]) begin
               status_in = ffha_pkg::StatusFail;
            end
         end
         S_A_LIM: begin
            alu_op = ffha_pkg::ALU_SUB;
            alu_a  = AW'(limit_ff);
            alu_b  = AW'(grow_ff);
            if (alu_res.borrow) begin
               status_in = ffha_pkg::StatusFail;
               state_in  = S_RESP;
            end else begin
               state_in = S_A_APP;
            end
         end
         S_A_APP: begin
            alu_op          = ffha_pkg::ALU_ADD_HDR;
            alu_a           = AW'(top_ff);
            alu_b           = '0;
            res_addr_in     = alu_res.value[15:0];
            top_in          = grow_ff;
            new_ent_in.free = 1'b0;
            new_ent_in.size = s_ff[SW-1:0];
            ins_pos_in      = cnt_ff;
            k_in            = cnt_ff;
            state_in        = S_IN_RD;
         end

         // Insert: move entries up by one, then place the new entry.
         S_IN_RD: begin
            if (k_ff > ins_pos_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IW'(k_ff - OneC);
               state_in = S_IN_WR;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ins_pos_ff[IW-1:0];
               wr_data  = new_ent_ff;
               cnt_in   = cnt_ff + OneC;
               state_in = S_RESP;
            end
         end
         S_IN_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff[IW-1:0];
            wr_data  = rd_data_ff;
            k_in     = k_ff - OneC;
            state_in = S_IN_RD;
         end

         // Free: find the block whose payload address matches.
         S_F_PRE: begin
            alu_op    = ffha_pkg::ALU_SUB;
            alu_a     = AW'(tgt_ff);
            alu_b     = HdrA;
            tgt_in    = alu_res.value[LW-1:0];
            tgt_ok_in = !alu_res.borrow;
            state_in  = S_F_RD;
         end
         S_F_RD: begin
            if (idx_ff == cnt_ff) begin
               status_in = ffha_pkg::StatusFail;
               state_in  = S_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_F_EV;
            end
         end
         S_F_EV: begin
            if (tgt_ok_ff && (off_ff == tgt_ff)) begin
               cur_in      = idx_ff;
               cur_size_in = rd_data_ff.size;
               cur_off_in  = off_ff;
               if ((idx_ff != '0) && prev_free_ff) begin
                  state_in = S_F_MRGP;
               end else begin
                  wr_en        = 1'b1;
                  wr_data.free = 1'b1;
                  wr_data.size = rd_data_ff.size;
                  state_in     = S_F_NXT;
               end
            end else begin
               state_in = S_F_STEP;
            end
         end
         S_F_STEP: begin
            alu_op       = ffha_pkg::ALU_ADD_HDR;
            alu_a        = AW'(off_ff);
            alu_b        = AW'(rd_data_ff.size);
            off_in       = alu_res.value[LW-1:0];
            prev_off_in  = off_ff;
            prev_size_in = rd_data_ff.size;
            prev_free_in = rd_data_ff.free;
            idx_in       = idx_ff + OneC;
            state_in     = S_F_RD;
         end

         // Free: merge into the free block below, then drop this entry.
         S_F_MRGP: begin
            alu_op       = ffha_pkg::ALU_ADD_HDR;
            alu_a        = AW'(prev_size_ff);
            alu_b        = AW'(cur_size_ff);
            wr_en        = 1'b1;
            wr_addr      = IW'(idx_ff - OneC);
            wr_data.free = 1'b1;
            wr_data.size = alu_res.value[SW-1:0];
            cur_size_in  = alu_res.value[SW-1:0];
            cur_in       = idx_ff - OneC;
            cur_off_in   = prev_off_ff;
            k_in         = idx_ff;
            rm_ret_in    = 1'b1;
            state_in     = S_RM_RD;
         end

         // Free: look at the block above, or release the top block.
         S_F_NXT: begin
            if ((cur_ff + OneC) < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IW'(cur_ff + OneC);
               state_in = S_F_NEV;
            end else begin
               top_in    = cur_off_ff;
               k_in      = cur_ff;
               rm_ret_in = 1'b0;
               state_in  = S_RM_RD;
            end
         end
         S_F_NEV: begin
            state_in = rd_data_ff.free ? S_F_MRGN : S_RESP;
         end
         S_F_MRGN: begin
            alu_op       = ffha_pkg::ALU_ADD_HDR;
            alu_a        = AW'(cur_size_ff);
            alu_b        = AW'(rd_data_ff.size);
            wr_en        = 1'b1;
            wr_addr      = cur_ff[IW-1:0];
            wr_data.free = 1'b1;
            wr_data.size = alu_res.value[SW-1:0];
            k_in         = cur_ff + OneC;
            rm_ret_in    = 1'b0;
            state_in     = S_RM_RD;
         end

         // Remove: move entries down by one over the removed slot.
         S_RM_RD: begin
            if ((k_ff + OneC) < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IW'(k_ff + OneC);
               state_in = S_RM_WR;
            end else begin
               cnt_in   = cnt_ff - OneC;
               state_in = rm_ret_ff ? S_F_NXT : S_RESP;
            end
         end
         S_RM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff[IW-1:0];
            wr_data  = rd_data_ff;
            k_in     = k_ff + OneC;
            state_in = S_RM_RD;
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_address = (status_ff == ffha_pkg::StatusOk) ?
                  res_addr_ff : 16'd0;
               rsp_data_in.status         = status_ff;
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         top_ff       <= '0;
         limit_ff     <= (ffha_pkg::LimitReset > LimitCap) ? LimitCap :
                         ffha_pkg::LimitReset;
         rsp_valid_ff <= 1'b0;
         rm_ret_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         rm_ret_ff    <= rm_ret_in;
      end
      s_ff         <= s_in;
      tgt_ff       <= tgt_in;
      tgt_ok_ff    <= tgt_ok_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      ins_pos_ff   <= ins_pos_in;
      off_ff       <= off_in;
      prev_off_ff  <= prev_off_in;
      prev_size_ff <= prev_size_in;
      prev_free_ff <= prev_free_in;
      cur_ff       <= cur_in;
      cur_size_ff  <= cur_size_in;
      cur_off_ff   <= cur_off_in;
      rem_ff       <= rem_in;
      split_ff     <= split_in;
      grow_ff      <= grow_in;
      new_ent_ff   <= new_ent_in;
      res_addr_ff  <= res_addr_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Block table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

endmodule

### sim/first_fit_heap_allocator_core_tb.sv
// Self-checking testbench for first_fit_heap_allocator_core: a queue-fed driver,
// a result monitor and a behavioral model of the block table. Depends on ffha_pkg.
module first_fit_heap_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Hdr = ffha_pkg::HeaderBytesDef;
   localparam int MaxBlk = ffha_pkg::MaxBlocksDef;
   localparam int CycleLimit = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ffha_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ffha_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ffha_pkg::LimitW-1:0] csr_data = '0;

   first_fit_heap_allocator_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Clock with a 4 ns period.
   initial begin
      forever #2 clock = ~clock;
   end

   // Model state of the block table.
   int unsigned tbl_size[MaxBlk];
   bit tbl_free[MaxBlk];
   int unsigned tbl_count;
   int unsigned top_off;
   int unsigned limit_reg;

   ffha_pkg::req_type pending_beats[$];
   ffha_pkg::rsp_type expected_rsps[$];
   int unsigned live_addrs[$];
   int errors = 0;
   bit quiet_phase = 1'b0;
   bit req_taken = 1'b0;
   int req_gap = 0;
   int rsp_gap = 0;
   longint cycles = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic void drop_entry(input int unsigned i);
      for (int unsigned k = i; k + 1 < tbl_count; k++) begin
         tbl_size[k] = tbl_size[k+1];
         tbl_free[k] = tbl_free[k+1];
      end
      tbl_count--;
   endfunction

   function automatic void add_entry(input int unsigned i, input int unsigned sz,
                                     input bit fr);
      for (int unsigned k = tbl_count; k > i; k--) begin
         tbl_size[k] = tbl_size[k-1];
         tbl_free[k] = tbl_free[k-1];
      end
      tbl_size[i] = sz;
      tbl_free[i] = fr;
      tbl_count++;
   endfunction

   // Allocate: first fit, split when room remains, else grow at the top.
   function automatic ffha_pkg::rsp_type model_alloc(input int unsigned size);
      ffha_pkg::rsp_type r;
      int unsigned s;
      int unsigned off;
      int unsigned lim;
      r.result_address = '0;
      r.status = ffha_pkg::StatusFail;
      off = 0;
      if (size == 0) return r;
      s = (((size - 1) >> 3) << 3) + 8;
      for (int unsigned i = 0; i < tbl_count; i++) begin
         if (tbl_free[i] && tbl_size[i] >= s) begin
            if (tbl_size[i] - s >= Hdr + 8 && tbl_count < MaxBlk) begin
               add_entry(i + 1, tbl_size[i] - s - Hdr, 1'b1);
               tbl_size[i] = s;
            end
            tbl_free[i] = 1'b0;
            r.result_address = 16'(off + Hdr);
            r.status = ffha_pkg::StatusOk;
            return r;
         end
         off += Hdr + tbl_size[i];
      end
      lim = limit_reg;
      if (lim > ffha_pkg::ArenaBytesDef) lim = ffha_pkg::ArenaBytesDef;
      if (lim > ffha_pkg::AddrSpace) lim = ffha_pkg::AddrSpace;
      if (tbl_count >= MaxBlk || top_off + Hdr + s > lim) return r;
      add_entry(tbl_count, s, 1'b0);
      r.result_address = 16'(top_off + Hdr);
      r.status = ffha_pkg::StatusOk;
      top_off += Hdr + s;
      return r;
   endfunction

   // Free: mark, merge with free neighbors, and release the top block.
   function automatic ffha_pkg::rsp_type model_free(input int unsigned addr);
      ffha_pkg::rsp_type r;
      int unsigned off;
      int unsigned cur;
      bit found;
      r.result_address = '0;
      r.status = ffha_pkg::StatusFail;
      off = 0;
      found = 1'b0;
      cur = 0;
      for (int unsigned i = 0; i < tbl_count; i++) begin
         if (off + Hdr == addr) begin
            found = 1'b1;
            cur = i;
            break;
         end
         off += Hdr + tbl_size[i];
      end
      if (!found) return r;
      r.status = ffha_pkg::StatusOk;
      tbl_free[cur] = 1'b1;
      if (cur > 0 && tbl_free[cur-1]) begin
         off -= Hdr + tbl_size[cur-1];
         tbl_size[cur-1] += Hdr + tbl_size[cur];
         drop_entry(cur);
         cur--;
      end
      if (cur + 1 < tbl_count) begin
         if (tbl_free[cur+1]) begin
            tbl_size[cur] += Hdr + tbl_size[cur+1];
            drop_entry(cur + 1);
         end
      end else begin
         drop_entry(cur);
         top_off = off;
      end
      return r;
   endfunction

   // Driver: one request beat per handshake, random gaps until the quiet phase.
   always @(negedge clock) begin
      if (!reset) begin
         // Move on only when the line is idle or the last beat was taken.
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
               if (!quiet_phase && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
            rsp_gap = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Request monitor: predict the result of each accepted beat.
   always @(posedge clock) begin
      cycles++;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         if (req_data.mode == ffha_pkg::ModeAlloc) begin
            expected_rsps.push_back(model_alloc(req_data.request_size));
         end else begin
            expected_rsps.push_back(model_free(req_data.address));
         end
      end
   end

   // Response monitor: compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      ffha_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result_address !== want.result_address)
               report_mismatch($sformatf("result_address %h, expected %h",
                  rsp_data.result_address, want.result_address));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %b, expected %b",
                  rsp_data.status, want.status));
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic ffha_pkg::req_type make_alloc(input int unsigned size);
      ffha_pkg::req_type b;
      b.mode = ffha_pkg::ModeAlloc;
      b.request_size = 16'(size);
      b.address = 16'($urandom);
      return b;
   endfunction

   function automatic ffha_pkg::req_type make_free(input int unsigned addr);
      ffha_pkg::req_type b;
      b.mode = ffha_pkg::ModeFree;
      b.request_size = 16'($urandom);
      b.address = 16'(addr);
      return b;
   endfunction

   // Wait until every queued beat is sent and every result has come back.
   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_limit(input int unsigned value);
      @(negedge clock);
      csr_data <= ffha_pkg::LimitW'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random mix: mostly allocates and frees of plausible payload addresses.
   task automatic random_phase(input int n, input int unsigned max_size);
      int unsigned addr;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if ($urandom_range(0, 19) == 0) addr = $urandom_range(0, 65535);
            else addr = $urandom_range(0, max_size);
            pending_beats.push_back(make_alloc(addr));
         end else if (pick < 92 && live_addrs.size() > 0) begin
            addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            pending_beats.push_back(make_free(addr));
         end else begin
            pending_beats.push_back(make_free($urandom_range(0, 65535)));
         end
         // Track granted addresses coarsely: candidate payload offsets.
         if (live_addrs.size() < 200)
            live_addrs.push_back(Hdr + 8 * $urandom_range(0, 200) +
               ($urandom_range(0, 1) ? 0 : Hdr * $urandom_range(0, 20)));
      end
   endtask

   // Stimulus.
   initial begin
      limit_reg = ffha_pkg::LimitReset;
      tbl_count = 0;
      top_off = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero size, extremes, split, merge, invalid and double free.
      pending_beats.push_back(make_alloc(0));
      pending_beats.push_back(make_alloc(1));
      pending_beats.push_back(make_alloc(100));
      pending_beats.push_back(make_alloc(8));
      pending_beats.push_back(make_free(88));
      pending_beats.push_back(make_free(88));
      pending_beats.push_back(make_alloc(16));
      pending_beats.push_back(make_free(41));
      pending_beats.push_back(make_free(16'hFFFF));
      pending_beats.push_back(make_free(40));
      pending_beats.push_back(make_free(88));
      pending_beats.push_back(make_alloc(65535));
      pending_beats.push_back(make_alloc(65440));
      pending_beats.push_back(make_free(40));
      pending_beats.push_back(make_alloc(65488));
      pending_beats.push_back(make_free(40));
      drain();

      // Fill the table with tiny blocks, then split attempts while full.
      for (int i = 0; i < 66; i++) pending_beats.push_back(make_alloc(8));
      for (int i = 0; i < 4; i++) pending_beats.push_back(make_free(40 + 96 * i));
      pending_beats.push_back(make_alloc(8));
      drain();
      for (int i = 63; i >= 0; i--) pending_beats.push_back(make_free(40 + 48 * i));
      drain();

      // Limit lowered below the top; existing blocks stay.
      pending_beats.push_back(make_alloc(200));
      drain();
      write_limit(0);
      pending_beats.push_back(make_alloc(8));
      pending_beats.push_back(make_free(40));
      pending_beats.push_back(make_alloc(8));
      drain();
      write_limit(131071);
      random_phase(350, 600);
      drain();
      write_limit(3000);
      live_addrs.delete();
      random_phase(350, 400);
      drain();
      write_limit(65536);
      live_addrs.delete();
      random_phase(300, 1500);
      drain();
      quiet_phase = 1'b1;
      write_limit($urandom_range(0, 131071));
      random_phase(250, 300);
      drain();

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

### files.f
hdl/ffha_pkg.sv
hdl/ffha_alu.sv
hdl/first_fit_heap_allocator_core.sv
sim/first_fit_heap_allocator_core_tb.sv
